// ===== sv/decimal_digit_display_refresh_top_macros.svh =====
// Assertion macros used by the digit display refresh RTL.
`ifndef DECIMAL_DIGIT_DISPLAY_REFRESH_TOP_MACROS_SVH
`define DECIMAL_DIGIT_DISPLAY_REFRESH_TOP_MACROS_SVH

// Same-cycle implication, sampled on clock, ignored during reset.
`define DDR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, ignored during reset.
`define DDR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/ddr_pkg.sv =====
// Shared constants, state type and control structs of the digit display refresh block.
package ddr_pkg;

   localparam int MAX_DIGITS = 16;
   localparam int DIGIT_SLOTS = 256;

   localparam logic [3:0] CODE_MINUS = 4'hA;
   localparam logic [3:0] CODE_BLANK = 4'hF;

   // floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for every 32-bit x
   localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;
   localparam int RECIP_SHIFT = 35;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRIME,
      ST_DIGITS,
      ST_DRAIN,
      ST_FLUSH
   } ddr_state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic issue_sign;
      logic issue_digit;
      logic flush;
   } ddr_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic sign_mode;
      logic no_digits;
      logic last_digit;
      logic advance;
   } ddr_status_type;

endpackage

// ===== sv/ddr_ctrl.sv =====
// Sequencer of the digit display refresh block.
module ddr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  ddr_pkg::ddr_status_type status,
   output ddr_pkg::ddr_cmd_type    cmd
);
   import ddr_pkg::*;

   ddr_state_type state_ff;
   ddr_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !status.count_zero) begin
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            if (status.advance) begin
               state_in = status.no_digits ? ST_DRAIN : ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (status.advance && status.last_digit) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (status.advance) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (status.advance) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_PRIME: begin
            cmd.step       = status.advance;
            cmd.issue_sign = status.advance && status.sign_mode;
         end
         ST_DIGITS: begin
            cmd.step        = status.advance;
            cmd.issue_digit = status.advance;
         end
         ST_DRAIN: begin
            cmd = '0;
         end
         ST_FLUSH: begin
            cmd.flush = status.advance;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== sv/ddr_datapath.sv =====
// Digit generator, shadow code store and output staging of the digit display refresh block.
`include "decimal_digit_display_refresh_top_macros.svh"

module ddr_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic signed [31:0]      req_display_value,
   input  logic        [7:0]       req_first_digit,
   input  logic        [4:0]       req_digit_count,
   input  logic signed [31:0]      req_range_min,
   input  logic signed [31:0]      req_range_max,
   input  ddr_pkg::ddr_cmd_type    cmd,
   output ddr_pkg::ddr_status_type status,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic        [7:0]       rsp_digit_position,
   output logic        [3:0]       rsp_digit_code,
   output logic                    rsp_last_of_run
);
   import ddr_pkg::*;

   // load-time decode
   logic        oor;
   logic        sign_mode;
   logic [4:0]  cnt_sat;
   logic [31:0] mag;

   // per-item registers
   logic [7:0]  first_ff;
   logic [7:0]  sign_pos_ff;
   logic [4:0]  ndig_ff;
   logic [3:0]  idx_ff;
   logic        oor_ff;
   logic        neg_ff;
   logic        sign_ff;

   // quotient chain: prev_ff = x, cur_ff = x / 10
   logic [31:0] prev_ff;
   logic [31:0] cur_ff;
   logic [63:0] prod;
   logic [3:0]  digit;

   logic        advance;
   logic        issue;
   logic [7:0]  issue_pos;
   logic [3:0]  issue_code;

   // check stage
   logic        chk_valid_ff;
   logic [7:0]  chk_pos_ff;
   logic [3:0]  chk_code_ff;
   logic [3:0]  code_rd_ff;
   logic        vld_rd_ff;
   logic        emit;

   logic [3:0]  shadow_mem [DIGIT_SLOTS];
   logic        slot_valid_ff [DIGIT_SLOTS];

   // held command, sent once the next one (or the end of the run) is known
   logic        pend_valid_ff;
   logic [7:0]  pend_pos_ff;
   logic [3:0]  pend_code_ff;

   logic        out_valid_ff;
   logic [7:0]  out_pos_ff;
   logic [3:0]  out_code_ff;
   logic        out_last_ff;

   assign oor       = (req_display_value < req_range_min) ||
                      (req_display_value > req_range_max);
   assign sign_mode = !oor && req_range_min[31];
   assign cnt_sat   = (req_digit_count > 5'(MAX_DIGITS)) ? 5'(MAX_DIGITS) : req_digit_count;
   assign mag       = req_display_value[31] ? (32'd0 - $unsigned(req_display_value))
                                            : $unsigned(req_display_value);

   assign prod  = {32'd0, cur_ff} * {32'd0, RECIP_10};
   assign digit = prev_ff[3:0] - 4'(cur_ff[3:0] * 4'd10);

   assign advance = !out_valid_ff || !rsp_stall;

   assign status.count_zero = (req_digit_count == 5'd0);
   assign status.sign_mode  = sign_ff;
   assign status.no_digits  = (ndig_ff == 5'd0);
   assign status.last_digit = (({1'b0, idx_ff} + 5'd1) == ndig_ff);
   assign status.advance    = advance;

   assign issue      = cmd.issue_sign || cmd.issue_digit;
   assign issue_pos  = cmd.issue_sign ? sign_pos_ff : (first_ff + {4'd0, idx_ff});
   assign issue_code = cmd.issue_sign ? (neg_ff ? CODE_MINUS : CODE_BLANK)
                                      : (oor_ff ? CODE_BLANK : digit);

   assign emit = chk_valid_ff && !(vld_rd_ff && (code_rd_ff == chk_code_ff));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         first_ff    <= req_first_digit;
         sign_pos_ff <= req_first_digit + 8'(cnt_sat) - 8'd1;
         ndig_ff     <= sign_mode ? (cnt_sat - 5'd1) : cnt_sat;
         idx_ff      <= '0;
         oor_ff      <= oor;
         neg_ff      <= req_display_value[31];
         sign_ff     <= sign_mode;
         cur_ff      <= mag;
      end else begin
         if (cmd.issue_digit) begin
            idx_ff <= idx_ff + 4'd1;
         end
         if (cmd.step) begin
            prev_ff <= cur_ff;
            cur_ff  <= {3'd0, prod[63:RECIP_SHIFT]};
         end
      end
   end

   // shadow store: registered read, write from the check stage
   always_ff @(posedge clock) begin
      if (advance) begin
         code_rd_ff <= shadow_mem[issue_pos];
         chk_pos_ff  <= issue_pos;
         chk_code_ff <= issue_code;
         if (emit) begin
            shadow_mem[chk_pos_ff] <= chk_code_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIGIT_SLOTS; i++) begin
            slot_valid_ff[i] <= 1'b0;
         end
         vld_rd_ff     <= 1'b0;
         chk_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else if (advance) begin
         vld_rd_ff    <= slot_valid_ff[issue_pos];
         chk_valid_ff <= issue;
         if (emit) begin
            slot_valid_ff[chk_pos_ff] <= 1'b1;
            pend_valid_ff <= 1'b1;
            out_valid_ff  <= pend_valid_ff;
         end else if (cmd.flush && pend_valid_ff) begin
            pend_valid_ff <= 1'b0;
            out_valid_ff  <= 1'b1;
         end else begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (emit) begin
            pend_pos_ff  <= chk_pos_ff;
            pend_code_ff <= chk_code_ff;
         end
         out_pos_ff  <= pend_pos_ff;
         out_code_ff <= pend_code_ff;
         out_last_ff <= !emit;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_digit_position = out_pos_ff;
   assign rsp_digit_code     = out_code_ff;
   assign rsp_last_of_run    = out_last_ff;

   `DDR_ASSERT_NOW(a_no_slot_clash, issue && chk_valid_ff, issue_pos != chk_pos_ff, "read and write hit the same slot")
   `DDR_ASSERT_NOW(a_digit_decimal, cmd.issue_digit && !oor_ff, digit <= 4'd9, "digit out of decimal range")
   `DDR_ASSERT_NEXT(a_flush_clears, cmd.flush, !pend_valid_ff, "held word survives flush")
   `DDR_ASSERT_NOW(a_flush_idle_pipe, cmd.flush, !chk_valid_ff && !issue, "flush with command in flight")

endmodule

// ===== sv/decimal_digit_display_refresh_top.sv =====
// Top level of the decimal digit display refresh block.
// Usage:
//  - req_ channel: one word carries a signed value and a display descriptor
//    (first digit position, digit count, range min and max). Accepted when
//    req_valid is high and req_stall low; req_stall is high while a word is
//    being worked on, so one word is handled at a time.
//  - rsp_ channel: one word per digit command (position, code, last flag).
//    Commands whose code the position already shows are dropped; the last
//    word sent for a request has rsp_last_of_run set. A request may yield
//    no words at all.
//  - Timing: a word (count saturated at 16) passes a prime step, a digit
//    step per digit (the prime step issues the sign if a sign position is
//    used), a drain and a flush step; a zero count stays in idle. Digits
//    leave one per cycle while rsp_ is not stalled; the 1/10 step is one
//    32x32 multiply per cycle and the shadow store read-compare-write adds
//    one stage. A result passes the check stage and the held word to rsp_.
//  - Stall: a stalled rsp_ word freezes the whole pipeline, including the
//    shadow store read; no word is lost or repeated.
//  - Reset: synchronous, marks all 256 shadow positions unknown at once
//    (valid flags), so the block is ready on the first cycle after reset.
module decimal_digit_display_refresh_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_display_value,
   input  logic        [7:0]  req_first_digit,
   input  logic        [4:0]  req_digit_count,
   input  logic signed [31:0] req_range_min,
   input  logic signed [31:0] req_range_max,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic        [7:0]  rsp_digit_position,
   output logic        [3:0]  rsp_digit_code,
   output logic               rsp_last_of_run
);
   import ddr_pkg::*;

   ddr_cmd_type    cmd;
   ddr_status_type status;

   // sequencer: walks prime, digit, drain and flush steps
   ddr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: quotient chain, shadow store, held word and output register
   ddr_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_display_value  (req_display_value),
      .req_first_digit    (req_first_digit),
      .req_digit_count    (req_digit_count),
      .req_range_min      (req_range_min),
      .req_range_max      (req_range_max),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digit_position (rsp_digit_position),
      .rsp_digit_code     (rsp_digit_code),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule
